// File: hdl/bmrm_pkg.sv
// ----------------------------------------------------------------------------
// bmrm_pkg
// Shared types and constants of the broadcast/multicast rate monitor.
// ----------------------------------------------------------------------------
package bmrm_pkg;

  // Tick rate used for the peak timestamps (seconds = ticks / rate)
  localparam int unsigned TICKS_PER_SECOND = 100;

  // Field widths
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned SECS_W = 26;
  localparam int unsigned BYTE_W = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORM_THRESHOLD = 1'd1;
  localparam logic [CNT_W-1:0] WINDOW_TICKS_RST    = 32'd1000;
  localparam logic [CNT_W-1:0] STORM_THRESHOLD_RST = 32'd1000;

  // Destination byte classification
  localparam logic [BYTE_W-1:0] BCAST_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] MCAST_MASK = 8'h01;

  // Divide by the tick rate: reciprocal estimate plus one correction step
  localparam int unsigned TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam logic [TPS_W-1:0] TPS_VAL = TPS_W'(TICKS_PER_SECOND);
  localparam int unsigned RECIP_W = CNT_W + 1;
  localparam logic [RECIP_W-1:0] SEC_RECIP =
    RECIP_W'((64'd1 << CNT_W) / 64'(TICKS_PER_SECOND));
  localparam int unsigned PROD_W = CNT_W + RECIP_W;
  localparam int unsigned QT_W   = CNT_W + TPS_W;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_BITS   = 6 * CNT_W + 2 * SECS_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  // Load strobes of the divider stages
  typedef struct packed {
    logic ld2;
    logic ld3;
  } bmrm_pipe_en_t;

  // One result item
  typedef struct packed {
    logic [CNT_W-1:0]  bc_count;
    logic [CNT_W-1:0]  mc_count;
    logic [CNT_W-1:0]  bc_hits;
    logic [CNT_W-1:0]  mc_hits;
    logic [CNT_W-1:0]  bc_peak;
    logic [SECS_W-1:0] bc_peak_second;
    logic [CNT_W-1:0]  mc_peak;
    logic [SECS_W-1:0] mc_peak_second;
  } bmrm_result_t;

endpackage

// File: hdl/bmrm_div.sv
// ----------------------------------------------------------------------------
// bmrm_div
// Two-stage divide of the tick count by the tick rate (reciprocal multiply,
// then a remainder check that adds the missing one).
// ----------------------------------------------------------------------------
module bmrm_div (
  input  logic                                clk_i,
  input  bmrm_pkg::bmrm_pipe_en_t             en_i,
  input  logic [bmrm_pkg::CNT_W-1:0]          now1_i,  // tick count, stage 1
  input  logic [bmrm_pkg::CNT_W-1:0]          now3_i,  // tick count, stage 3
  output logic [bmrm_pkg::SECS_W-1:0]         secs_o
);

  logic [bmrm_pkg::PROD_W-1:0] prod;
  logic [bmrm_pkg::QT_W-1:0]   qt_full;
  logic [bmrm_pkg::CNT_W-1:0]  q0_s2_q;
  logic [bmrm_pkg::CNT_W-1:0]  q0_s3_q;
  logic [bmrm_pkg::CNT_W-1:0]  qt_s3_q;
  logic [bmrm_pkg::CNT_W-1:0]  rem;
  logic                        carry;
  logic [bmrm_pkg::CNT_W-1:0]  secs_full;

  // Estimate: floor(now * floor(2^32 / rate) / 2^32), low by at most one
  assign prod = bmrm_pkg::PROD_W'(now1_i) * bmrm_pkg::PROD_W'(bmrm_pkg::SEC_RECIP);

  // Estimate times rate, never above now
  assign qt_full = bmrm_pkg::QT_W'(q0_s2_q) * bmrm_pkg::QT_W'(bmrm_pkg::TPS_VAL);

  always_ff @(posedge clk_i) begin
    if (en_i.ld2) begin
      q0_s2_q <= prod[bmrm_pkg::CNT_W +: bmrm_pkg::CNT_W];
    end
    if (en_i.ld3) begin
      q0_s3_q <= q0_s2_q;
      qt_s3_q <= qt_full[bmrm_pkg::CNT_W-1:0];
    end
  end

  // Correction: remainder still a full rate means the estimate was one short
  assign rem       = now3_i - qt_s3_q;
  assign carry     = (rem >= bmrm_pkg::CNT_W'(bmrm_pkg::TPS_VAL));
  assign secs_full = q0_s3_q + bmrm_pkg::CNT_W'(carry);
  assign secs_o    = secs_full[bmrm_pkg::SECS_W-1:0];

endmodule

// File: hdl/bmrm_core.sv
// ----------------------------------------------------------------------------
// bmrm_core
// Configuration registers, window state and counters; updates once per item.
// ----------------------------------------------------------------------------
module bmrm_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bmrm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bmrm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                upd_i,
  input  logic [bmrm_pkg::CNT_W-1:0]          now_i,
  input  logic [bmrm_pkg::BYTE_W-1:0]         dest_i,
  input  logic [bmrm_pkg::SECS_W-1:0]         secs_i,
  output bmrm_pkg::bmrm_result_t              res_o
);

  logic [bmrm_pkg::CNT_W-1:0]  window_ticks_q;
  logic [bmrm_pkg::CNT_W-1:0]  threshold_q;
  logic [bmrm_pkg::CNT_W-1:0]  start_q;
  logic [bmrm_pkg::CNT_W-1:0]  end_q, end_d;
  logic [bmrm_pkg::CNT_W-1:0]  bc_frames_q, bc_frames_d;
  logic [bmrm_pkg::CNT_W-1:0]  mc_frames_q, mc_frames_d;
  logic [bmrm_pkg::CNT_W-1:0]  bc_hits_q, bc_hits_d;
  logic [bmrm_pkg::CNT_W-1:0]  mc_hits_q, mc_hits_d;
  logic [bmrm_pkg::CNT_W-1:0]  bc_peak_q, bc_peak_d;
  logic [bmrm_pkg::CNT_W-1:0]  mc_peak_q, mc_peak_d;
  logic [bmrm_pkg::SECS_W-1:0] bc_time_q, bc_time_d;
  logic [bmrm_pkg::SECS_W-1:0] mc_time_q, mc_time_d;
  logic [bmrm_pkg::CNT_W-1:0]  diff;
  logic [bmrm_pkg::CNT_W-1:0]  bc_base, mc_base;
  logic                        closed;
  logic                        is_bc, is_mc;

  // Window end test against the precomputed end tick (wrap-aware)
  assign diff   = now_i - end_q;
  assign closed = ~diff[bmrm_pkg::CNT_W-1];

  // Frame class
  assign is_bc = (dest_i == bmrm_pkg::BCAST_BYTE);
  assign is_mc = ~is_bc && ((dest_i & bmrm_pkg::MCAST_MASK) != '0);

  // Next state
  always_comb begin
    bc_hits_d = bc_hits_q;
    mc_hits_d = mc_hits_q;
    bc_peak_d = bc_peak_q;
    mc_peak_d = mc_peak_q;
    bc_time_d = bc_time_q;
    mc_time_d = mc_time_q;
    bc_base   = bc_frames_q;
    mc_base   = mc_frames_q;
    end_d     = end_q;
    if (closed) begin
      if (bc_frames_q >= threshold_q) begin
        bc_hits_d = bc_hits_q + bmrm_pkg::CNT_W'(1);
      end
      if (mc_frames_q >= threshold_q) begin
        mc_hits_d = mc_hits_q + bmrm_pkg::CNT_W'(1);
      end
      if (bc_frames_q > bc_peak_q) begin
        bc_peak_d = bc_frames_q;
        bc_time_d = secs_i;
      end
      if (mc_frames_q > mc_peak_q) begin
        mc_peak_d = mc_frames_q;
        mc_time_d = secs_i;
      end
      bc_base = '0;
      mc_base = '0;
      end_d   = now_i + window_ticks_q;
    end
    bc_frames_d = bc_base + bmrm_pkg::CNT_W'(is_bc);
    mc_frames_d = mc_base + bmrm_pkg::CNT_W'(is_mc);
  end

  // Result shows the state after this item
  always_comb begin
    res_o.bc_count       = bc_frames_d;
    res_o.mc_count       = mc_frames_d;
    res_o.bc_hits        = bc_hits_d;
    res_o.mc_hits        = mc_hits_d;
    res_o.bc_peak        = bc_peak_d;
    res_o.bc_peak_second = bc_time_d;
    res_o.mc_peak        = mc_peak_d;
    res_o.mc_peak_second = mc_time_d;
  end

  // State and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ticks_q <= bmrm_pkg::WINDOW_TICKS_RST;
      threshold_q    <= bmrm_pkg::STORM_THRESHOLD_RST;
      start_q        <= '0;
      end_q          <= bmrm_pkg::WINDOW_TICKS_RST;
      bc_frames_q    <= '0;
      mc_frames_q    <= '0;
      bc_hits_q      <= '0;
      mc_hits_q      <= '0;
      bc_peak_q      <= '0;
      mc_peak_q      <= '0;
      bc_time_q      <= '0;
      mc_time_q      <= '0;
    end else if (upd_i) begin
      if (closed) begin
        start_q <= now_i;
      end
      end_q       <= end_d;
      bc_frames_q <= bc_frames_d;
      mc_frames_q <= mc_frames_d;
      bc_hits_q   <= bc_hits_d;
      mc_hits_q   <= mc_hits_d;
      bc_peak_q   <= bc_peak_d;
      mc_peak_q   <= mc_peak_d;
      bc_time_q   <= bc_time_d;
      mc_time_q   <= mc_time_d;
    end else if (cfg_we_i) begin
      // user rule, not enforced: written only while idle, so start_q is settled here
      case (cfg_idx_i)
        bmrm_pkg::CFG_WINDOW_TICKS: begin
          window_ticks_q <= cfg_data_i;
          end_q          <= start_q + cfg_data_i;
        end
        bmrm_pkg::CFG_STORM_THRESHOLD: begin
          threshold_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/bcast_mcast_rate_monitor.sv
// ----------------------------------------------------------------------------
// bcast_mcast_rate_monitor
// Broadcast/multicast storm monitor over fixed tick windows.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per received frame, tdata = tick count and first
//   destination MAC byte. Master stream: one result item per input item,
//   carrying current window counts, hit counters and per-class peaks with
//   their time in seconds.
//   Config port: write window_ticks (index 0) or storm_threshold (index 1)
//   with cfg_we_i; only while no item is in flight.
//   Pipeline: four register stages (input, reciprocal multiply, correction
//   multiply, result). Throughput: one item per cycle while the receiver
//   does not stall; the window update is done in the last stage.
//   Receiver stall: the result register holds; the upstream stages keep
//   accepting until all four stages are full, then s_axis_tready drops.
//   Reset: all counters, peaks and the window start clear to zero, the
//   window length and threshold return to 1000, the pipeline empties.
// ----------------------------------------------------------------------------
module bcast_mcast_rate_monitor (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input items
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] now_ticks, [39:32] dest_first_byte
  input  logic [bmrm_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // result items
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [31:0] bc_count, [63:32] mc_count, [95:64] bc_hits, [127:96] mc_hits,
  // [159:128] bc_peak, [185:160] bc_peak_second, [217:186] mc_peak,
  // [243:218] mc_peak_second, [247:244] zero
  output logic [bmrm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [bmrm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bmrm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic                         v1_q, v2_q, v3_q, vo_q;
  logic                         rdy1, rdy2, rdy3, rdy4;
  logic                         upd;
  logic [bmrm_pkg::CNT_W-1:0]   now1_q, now2_q, now3_q;
  logic [bmrm_pkg::BYTE_W-1:0]  dest1_q, dest2_q, dest3_q;
  logic [bmrm_pkg::SECS_W-1:0]  secs;
  bmrm_pkg::bmrm_pipe_en_t      pipe_en;
  bmrm_pkg::bmrm_result_t       res_next;
  bmrm_pkg::bmrm_result_t       res_q;

  // Per-stage ready: a stage loads when empty or when it hands on
  assign rdy4 = ~vo_q | m_axis_tready;
  assign rdy3 = ~v3_q | rdy4;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;
  assign upd  = v3_q & rdy4;

  assign s_axis_tready = rdy1;
  assign pipe_en.ld2   = rdy2;
  assign pipe_en.ld3   = rdy3;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        vo_q <= v3_q;
      end
    end
  end

  // Item payload through the stages
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      now1_q  <= s_axis_tdata[bmrm_pkg::CNT_W-1:0];
      dest1_q <= s_axis_tdata[bmrm_pkg::CNT_W +: bmrm_pkg::BYTE_W];
    end
    if (rdy2) begin
      now2_q  <= now1_q;
      dest2_q <= dest1_q;
    end
    if (rdy3) begin
      now3_q  <= now2_q;
      dest3_q <= dest2_q;
    end
    if (upd) begin
      res_q <= res_next;
    end
  end

  // Seconds timestamp
  bmrm_div u_div (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .now1_i (now1_q),
    .now3_i (now3_q),
    .secs_o (secs)
  );

  // Window state and counters
  bmrm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .upd_i      (upd),
    .now_i      (now3_q),
    .dest_i     (dest3_q),
    .secs_i     (secs),
    .res_o      (res_next)
  );

  // Result stream
  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {{bmrm_pkg::OUT_PAD_W{1'b0}},
                          res_q.mc_peak_second, res_q.mc_peak,
                          res_q.bc_peak_second, res_q.bc_peak,
                          res_q.mc_hits, res_q.bc_hits,
                          res_q.mc_count, res_q.bc_count};

endmodule

// File: hdl/bmrm_checker.sv
// ----------------------------------------------------------------------------
// bmrm_checker
// Port-level checks of the rate monitor, bound to the top level.
// ----------------------------------------------------------------------------
module bmrm_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic [bmrm_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  logic                        in_fire, out_fire;
  logic [2:0]                  pend_q;
  logic [bmrm_pkg::CNT_W-1:0]  bc_hits_q, bc_peak_q;
  logic [bmrm_pkg::CNT_W-1:0]  bc_hits, bc_peak;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;
  assign bc_hits  = m_axis_tdata[64 +: bmrm_pkg::CNT_W];
  assign bc_peak  = m_axis_tdata[128 +: bmrm_pkg::CNT_W];

  // Items in flight and last delivered broadcast figures
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      bc_hits_q <= '0;
      bc_peak_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_fire) - 3'(out_fire);
      if (out_fire) begin
        bc_hits_q <= bc_hits;
        bc_peak_q <= bc_peak;
      end
    end
  end

  // a result only for an accepted item
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("result without an accepted item");

  // hit counter moves by at most one window per item
  a_hits_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (bc_hits == bc_hits_q || bc_hits == bc_hits_q + 32'd1))
    else $error("broadcast hit counter jumped");

  // peak never falls
  a_peak_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> bc_peak >= bc_peak_q)
    else $error("broadcast peak decreased");

  // stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

endmodule

bind bcast_mcast_rate_monitor bmrm_checker u_bmrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
